FILE: sv/enmx_pkg.sv
// shared types and constants for the edid monitor name extractor
// no dependencies; imported by enmx_cell and the top level
package enmx_pkg;

   localparam int unsigned NAME_MAX = 13;
   localparam int unsigned TXT_LEN  = 8;

   localparam logic [7:0] BLOCK_LEN   = 8'd128;
   localparam logic [7:0] DESC_FIRST  = 8'd54;
   localparam logic [7:0] DESC_END    = 8'd126;
   localparam logic [7:0] POS_VEND_HI = 8'd8;
   localparam logic [7:0] POS_VEND_LO = 8'd9;
   localparam logic [7:0] POS_PROD_LO = 8'd10;
   localparam logic [7:0] POS_PROD_HI = 8'd11;

   localparam logic [4:0] DESC_HDR0 = 5'd0;
   localparam logic [4:0] DESC_HDR1 = 5'd1;
   localparam logic [4:0] DESC_TAG  = 5'd3;
   localparam logic [4:0] DESC_NAME = 5'd5;
   localparam logic [4:0] DESC_LAST = 5'd17;

   localparam logic [7:0] TAG_NAME   = 8'hFC;
   localparam logic [7:0] CHR_NUL    = 8'h00;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_DEL    = 8'h7F;
   localparam logic [7:0] CHR_QUEST  = 8'h3F;
   localparam logic [7:0] CHR_AT     = 8'h40;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] res;
      if (nib < 4'd10) begin
         res = 8'h30 + {4'd0, nib};
      end else begin
         res = 8'h37 + {4'd0, nib};
      end
      return res;
   endfunction

   function automatic logic [7:0] vendor_letter(input logic [4:0] code);
      return CHR_AT + {3'd0, code};
   endfunction

endpackage

FILE: sv/enmx_cell.sv
// one character cell of the name chain: loads a character or takes its neighbor's
// depends on enmx_pkg for the control struct
module enmx_cell (
   input  logic                   clock,
   input  enmx_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]             load_char,
   input  logic [7:0]             next_char,
   output logic [7:0]             cell_char
);
   import enmx_pkg::*;

   logic [7:0] char_ff;
   logic [7:0] char_in;

   always_comb begin
      char_in = char_ff;
      if (ctrl.shift) begin
         char_in = next_char;
      end else if (ctrl.load) begin
         char_in = load_char;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   assign cell_char = char_ff;

endmodule

FILE: sv/edid_monitor_name_extractor_unit.sv
// order: the end-marked item is parsed in its accept cycle, the finish state
// follows, then the first result item is shown; results leave one per cycle while rsp_tready is high
// throughput: one input item per cycle while idle; 1 to 13 result items per block,
// shifted out of the row of 13 character cells; input is held off during output
// reset: synchronous, active high; clears parse and control state, cells keep data
// top level; depends on enmx_pkg and enmx_cell
module edid_monitor_name_extractor_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // end_of_data
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,   // last
   output logic       rsp_tuser    // [0] no_name
);
   import enmx_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_FINISH = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [7:0]  idx_ff, idx_in;
   logic [4:0]  dpos_ff, dpos_in;
   logic [3:0]  cc_ff, cc_in;
   logic [3:0]  kept_ff, kept_in;
   logic        stop_ff, stop_in;
   logic        hm_ff, hm_in;
   logic        found_ff, found_in;
   logic [15:0] vend_ff, vend_in;
   logic [15:0] prod_ff, prod_in;
   logic [3:0]  remain_ff, remain_in;
   logic        noname_ff, noname_in;

   logic        in_acc, out_acc, in_blk, in_desc;
   logic [7:0]  byte_v, conv_char;
   logic [7:0]  txt [TXT_LEN];
   logic [NAME_MAX-1:0] cap_wr, fin_ld;
   logic [7:0]  ld_char [NAME_MAX];
   logic [7:0]  cell_out [NAME_MAX];
   cell_ctrl_type ctrl [NAME_MAX];

   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;
   assign byte_v  = req_tdata;
   assign in_blk  = (idx_ff < BLOCK_LEN);
   assign in_desc = in_blk && (idx_ff >= DESC_FIRST) && (idx_ff < DESC_END);
   assign conv_char = ((byte_v >= CHR_SPACE) && (byte_v < CHR_DEL)) ? byte_v : CHR_QUEST;

   assign txt[0] = vendor_letter(vend_ff[14:10]);
   assign txt[1] = vendor_letter(vend_ff[9:5]);
   assign txt[2] = vendor_letter(vend_ff[4:0]);
   assign txt[3] = CHR_SPACE;
   assign txt[4] = hex_digit(prod_ff[15:12]);
   assign txt[5] = hex_digit(prod_ff[11:8]);
   assign txt[6] = hex_digit(prod_ff[7:4]);
   assign txt[7] = hex_digit(prod_ff[3:0]);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      dpos_in   = dpos_ff;
      cc_in     = cc_ff;
      kept_in   = kept_ff;
      stop_in   = stop_ff;
      hm_in     = hm_ff;
      found_in  = found_ff;
      vend_in   = vend_ff;
      prod_in   = prod_ff;
      remain_in = remain_ff;
      noname_in = noname_ff;
      cap_wr    = '0;
      fin_ld    = '0;
      for (int i = 0; i < NAME_MAX; i++) begin
         ld_char[i] = conv_char;
      end

      case (state_ff)
         ST_IDLE: begin
            if (in_acc) begin
               if (req_tlast) begin
                  state_in = ST_FINISH;
               end
               if (in_blk) begin
                  idx_in = idx_ff + 8'd1;
                  if (idx_ff == POS_VEND_HI) vend_in[15:8] = byte_v;
                  if (idx_ff == POS_VEND_LO) vend_in[7:0] = byte_v;
                  if (idx_ff == POS_PROD_LO) prod_in[7:0] = byte_v;
                  if (idx_ff == POS_PROD_HI) prod_in[15:8] = byte_v;
                  if (in_desc) begin
                     dpos_in = (dpos_ff == DESC_LAST) ? 5'd0 : dpos_ff + 5'd1;
                  end
                  if (in_desc && !found_ff) begin
                     case (dpos_ff)
                        DESC_HDR0: begin
                           hm_in   = (byte_v == CHR_NUL);
                           cc_in   = '0;
                           kept_in = '0;
                           stop_in = 1'b0;
                        end
                        DESC_HDR1: hm_in = hm_ff && (byte_v == CHR_NUL);
                        DESC_TAG:  hm_in = hm_ff && (byte_v == TAG_NAME);
                        default: begin
                           if (dpos_ff >= DESC_NAME && hm_ff && !stop_ff) begin
                              if (byte_v == CHR_LF || byte_v == CHR_NUL) begin
                                 stop_in = 1'b1;
                              end else if (cc_ff < 4'(NAME_MAX)) begin
                                 for (int i = 0; i < NAME_MAX; i++) begin
                                    cap_wr[i] = (cc_ff == 4'(i));
                                 end
                                 cc_in = cc_ff + 4'd1;
                                 if (conv_char != CHR_SPACE) kept_in = cc_ff + 4'd1;
                              end
                           end
                        end
                     endcase
                     if (dpos_ff == DESC_LAST && hm_in && kept_in != 4'd0) begin
                        found_in = 1'b1;
                     end
                  end
               end
            end
         end
         ST_FINISH: begin
            state_in = ST_EMIT;
            if (in_blk) begin
               fin_ld[0]  = 1'b1;
               ld_char[0] = CHR_NUL;
               remain_in  = 4'd1;
               noname_in  = 1'b1;
            end else if (found_ff) begin
               remain_in  = kept_ff;
               noname_in  = 1'b0;
            end else begin
               for (int i = 0; i < TXT_LEN; i++) begin
                  fin_ld[i]  = 1'b1;
                  ld_char[i] = txt[i];
               end
               remain_in  = 4'(TXT_LEN);
               noname_in  = 1'b0;
            end
            idx_in   = '0;
            dpos_in  = '0;
            cc_in    = '0;
            kept_in  = '0;
            stop_in  = 1'b0;
            hm_in    = 1'b0;
            found_in = 1'b0;
            vend_in  = '0;
            prod_in  = '0;
         end
         ST_EMIT: begin
            if (out_acc) begin
               remain_in = remain_ff - 4'd1;
               if (remain_ff == 4'd1) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= '0;
         dpos_ff   <= '0;
         cc_ff     <= '0;
         kept_ff   <= '0;
         stop_ff   <= 1'b0;
         hm_ff     <= 1'b0;
         found_ff  <= 1'b0;
         vend_ff   <= '0;
         prod_ff   <= '0;
         remain_ff <= '0;
         noname_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         dpos_ff   <= dpos_in;
         cc_ff     <= cc_in;
         kept_ff   <= kept_in;
         stop_ff   <= stop_in;
         hm_ff     <= hm_in;
         found_ff  <= found_in;
         vend_ff   <= vend_in;
         prod_ff   <= prod_in;
         remain_ff <= remain_in;
         noname_ff <= noname_in;
      end
   end

   // row of character cells, shifting toward cell 0 on output
   for (genvar g = 0; g < NAME_MAX; g++) begin : g_cell
      assign ctrl[g].shift = (state_ff == ST_EMIT) && out_acc;
      assign ctrl[g].load  = cap_wr[g] || fin_ld[g];
      if (g == NAME_MAX - 1) begin : g_end
         enmx_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl[g]),
            .load_char (ld_char[g]),
            .next_char (CHR_NUL),
            .cell_char (cell_out[g])
         );
      end else begin : g_mid
         enmx_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl[g]),
            .load_char (ld_char[g]),
            .next_char (cell_out[g+1]),
            .cell_char (cell_out[g])
         );
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = cell_out[0];
   assign rsp_tlast  = (remain_ff == 4'd1);
   assign rsp_tuser  = noname_ff;

`ifndef NO_ASSERTIONS
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (remain_ff != 4'd0) && (remain_ff <= 4'(NAME_MAX)))
      else $error("output with no characters left");
   a_end_finish: assert property (@(posedge clock) disable iff (reset)
      (in_acc && req_tlast) |=> (state_ff == ST_FINISH))
      else $error("end item did not start finish");
   a_noname_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("empty marker is not a single item");
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> (idx_ff == 8'd0) && !found_ff)
      else $error("parse state not cleared after finish");
`endif

endmodule
